// File: rtl/csmabo_pkg.sv
// Shared types, constants and helpers for the CSMA/CA backoff controller.
package csmabo_pkg;

  localparam int RANDOM_BITS = 10;  // width of the random word and of the slot counter
  localparam int CW_MIN_EXP  = 3;   // smallest contention window exponent
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int NTX_W       = 6;
  localparam int RETRY_W     = 4;
  localparam int EXP_W       = 5;   // wide enough for retry count plus the minimum exponent

  localparam logic [RETRY_W-1:0] RETRY_MAX = '1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DIFS_TICKS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CW_MAX_EXPONENT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TICKS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_WAIT_TICKS  = 3'd4;

  // phase codes as seen on the result channel
  localparam logic [2:0] PHASE_CODE_IDLE    = 3'd0;
  localparam logic [2:0] PHASE_CODE_DIFS    = 3'd1;
  localparam logic [2:0] PHASE_CODE_BACKOFF = 3'd2;
  localparam logic [2:0] PHASE_CODE_TX      = 3'd3;
  localparam logic [2:0] PHASE_CODE_TIMEOUT = 3'd4;
  localparam logic [2:0] PHASE_CODE_ACK     = 3'd5;

  typedef enum logic [5:0] {
    PH_IDLE    = 6'b000001,
    PH_DIFS    = 6'b000010,
    PH_BACKOFF = 6'b000100,
    PH_TX      = 6'b001000,
    PH_TIMEOUT = 6'b010000,
    PH_ACK     = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [7:0]  difs_ticks;
    logic [3:0]  cw_max_exponent;
    logic [3:0]  retry_limit;
    logic [15:0] frame_ticks;
    logic [7:0]  ack_wait_ticks;
  } cfg_t;

  typedef struct packed {
    logic                   medium_busy;
    logic [NTX_W-1:0]       tx_stations;
    logic [RANDOM_BITS-1:0] random_word;
    logic                   new_frame;
  } tick_t;

  typedef struct packed {
    logic [2:0]             phase;
    logic                   is_sending;
    logic                   is_awaiting_ack;
    logic                   backoff_drawn;
    logic                   frame_dropped;
    logic                   collision_seen;
    logic                   frame_delivered;
    logic                   ack_complete;
    logic [RANDOM_BITS-1:0] slots_left;
    logic [RETRY_W-1:0]     retry_value;
  } result_t;

  function automatic logic [2:0] phase_code(input phase_t ph);
    logic [2:0] code;
    unique case (ph)
      PH_IDLE:    code = PHASE_CODE_IDLE;
      PH_DIFS:    code = PHASE_CODE_DIFS;
      PH_BACKOFF: code = PHASE_CODE_BACKOFF;
      PH_TX:      code = PHASE_CODE_TX;
      PH_TIMEOUT: code = PHASE_CODE_TIMEOUT;
      PH_ACK:     code = PHASE_CODE_ACK;
      default:    code = PHASE_CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

// File: rtl/csmabo_tick_if.sv
// Tick input channel: valid/ready handshake with per-tick channel status.
interface csmabo_tick_if;
  logic                                valid;
  logic                                ready;
  logic                                medium_busy;
  logic [csmabo_pkg::NTX_W-1:0]        tx_stations;
  logic [csmabo_pkg::RANDOM_BITS-1:0]  random_word;
  logic                                new_frame;

  modport source (output valid, medium_busy, tx_stations, random_word, new_frame,
                  input ready);
  modport sink   (input valid, medium_busy, tx_stations, random_word, new_frame,
                  output ready);
endinterface

// File: rtl/csmabo_result_if.sv
// Result channel: valid/ready handshake with the per-tick station status.
interface csmabo_result_if;
  logic                                valid;
  logic                                ready;
  logic [2:0]                          phase;
  logic                                is_sending;
  logic                                is_awaiting_ack;
  logic                                backoff_drawn;
  logic                                frame_dropped;
  logic                                collision_seen;
  logic                                frame_delivered;
  logic                                ack_complete;
  logic [csmabo_pkg::RANDOM_BITS-1:0]  slots_left;
  logic [csmabo_pkg::RETRY_W-1:0]      retry_value;

  modport source (output valid, phase, is_sending, is_awaiting_ack, backoff_drawn,
                  frame_dropped, collision_seen, frame_delivered, ack_complete,
                  slots_left, retry_value, input ready);
  modport sink   (input valid, phase, is_sending, is_awaiting_ack, backoff_drawn,
                  frame_dropped, collision_seen, frame_delivered, ack_complete,
                  slots_left, retry_value, output ready);
endinterface

// File: rtl/csmabo_cfg_if.sv
// Configuration write channel: register index and write data.
interface csmabo_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [csmabo_pkg::CFG_IDX_W-1:0]   index;
  logic [csmabo_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/csmabo_cfg_regs.sv
// Configuration register file, written through the configuration channel.
module csmabo_cfg_regs (
  input  logic                clk,
  input  logic                rst,
  csmabo_cfg_if.sink          cfg,
  output csmabo_pkg::cfg_t    regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.difs_ticks      <= 8'd2;
      regs.cw_max_exponent <= 4'd10;
      regs.retry_limit     <= 4'd6;
      regs.frame_ticks     <= 16'd10;
      regs.ack_wait_ticks  <= 8'd1;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        csmabo_pkg::CFG_DIFS_TICKS:      regs.difs_ticks      <= cfg.data[7:0];
        csmabo_pkg::CFG_CW_MAX_EXPONENT: regs.cw_max_exponent <= cfg.data[3:0];
        csmabo_pkg::CFG_RETRY_LIMIT:     regs.retry_limit     <= cfg.data[3:0];
        csmabo_pkg::CFG_FRAME_TICKS:     regs.frame_ticks     <= cfg.data;
        csmabo_pkg::CFG_ACK_WAIT_TICKS:  regs.ack_wait_ticks  <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/csmabo_core.sv
// Station state machine, timers and next-state logic for one tick.
module csmabo_core #(
  parameter int TIMER_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  csmabo_pkg::tick_t     tick,
  input  csmabo_pkg::cfg_t      cfg,
  output csmabo_pkg::result_t   res
);

  localparam int RB = csmabo_pkg::RANDOM_BITS;
  localparam int RW = csmabo_pkg::RETRY_W;
  localparam int EW = csmabo_pkg::EXP_W;

  csmabo_pkg::phase_t phase, phase_next;
  logic [7:0]            difs_left, difs_left_next;
  logic [RB-1:0]         backoff_left, backoff_left_next;
  logic [RB-1:0]         paused_slots, paused_slots_next;
  logic [TIMER_BITS-1:0] tx_left, tx_left_next;
  logic [7:0]            timeout_left, timeout_left_next;
  logic [8:0]            ack_left, ack_left_next;
  logic [RW-1:0]         retry_cnt, retry_cnt_next;
  logic                  frame_pending, frame_pending_next;

  logic                  pending;
  logic [7:0]            difs_dec;
  logic [RB-1:0]         backoff_dec;
  logic [TIMER_BITS-1:0] tx_dec;
  logic [7:0]            timeout_dec;
  logic [8:0]            ack_dec;
  logic [EW-1:0]         exp_sel;
  logic [RB-1:0]         cw_mask;
  logic [RB-1:0]         draw;
  logic                  drawn, dropped, coll, deliv, ackc;

  // contention window exponent: min(retry + 3, cw_max_exponent, RANDOM_BITS)
  always_comb begin
    exp_sel = EW'(retry_cnt) + EW'(csmabo_pkg::CW_MIN_EXP);
    if (exp_sel > EW'(cfg.cw_max_exponent)) exp_sel = EW'(cfg.cw_max_exponent);
    if (exp_sel > EW'(RB)) exp_sel = EW'(RB);
    for (int i = 0; i < RB; i++) begin
      cw_mask[i] = (EW'(i) < exp_sel);
    end
  end

  assign pending     = frame_pending | tick.new_frame;
  assign difs_dec    = difs_left - 8'd1;
  assign backoff_dec = (backoff_left != '0) ? backoff_left - RB'(1) : backoff_left;
  assign tx_dec      = tx_left - TIMER_BITS'(1);
  assign timeout_dec = timeout_left - 8'd1;
  assign ack_dec     = ack_left - 9'd1;
  assign draw        = tick.random_word & cw_mask;

  always_comb begin
    phase_next         = phase;
    difs_left_next     = difs_left;
    backoff_left_next  = backoff_left;
    paused_slots_next  = paused_slots;
    tx_left_next       = tx_left;
    timeout_left_next  = timeout_left;
    ack_left_next      = ack_left;
    retry_cnt_next     = retry_cnt;
    frame_pending_next = pending;
    drawn   = 1'b0;
    dropped = 1'b0;
    coll    = 1'b0;
    deliv   = 1'b0;
    ackc    = 1'b0;

    unique case (phase)
      csmabo_pkg::PH_IDLE: begin
        if (pending && !tick.medium_busy) begin
          phase_next     = csmabo_pkg::PH_DIFS;
          difs_left_next = cfg.difs_ticks;
        end
      end
      csmabo_pkg::PH_DIFS: begin
        if (tick.medium_busy) begin
          phase_next = csmabo_pkg::PH_IDLE;
        end else begin
          difs_left_next = difs_dec;
          if (difs_dec == 8'd0) begin
            if (paused_slots != '0) begin
              // resume the backoff that a busy channel interrupted
              backoff_left_next = paused_slots;
              paused_slots_next = '0;
              phase_next        = csmabo_pkg::PH_BACKOFF;
            end else if (retry_cnt > cfg.retry_limit) begin
              dropped            = 1'b1;
              retry_cnt_next     = '0;
              frame_pending_next = 1'b0;
              phase_next         = csmabo_pkg::PH_IDLE;
            end else begin
              backoff_left_next = draw;
              drawn             = 1'b1;
              if (draw != '0) begin
                phase_next = csmabo_pkg::PH_BACKOFF;
              end else begin
                phase_next   = csmabo_pkg::PH_TX;
                tx_left_next = TIMER_BITS'(cfg.frame_ticks);
              end
            end
          end
        end
      end
      csmabo_pkg::PH_BACKOFF: begin
        if (tick.medium_busy) begin
          paused_slots_next = backoff_left;
          phase_next        = csmabo_pkg::PH_IDLE;
        end else begin
          backoff_left_next = backoff_dec;
          if (backoff_dec == '0) begin
            phase_next   = csmabo_pkg::PH_TX;
            tx_left_next = TIMER_BITS'(cfg.frame_ticks);
          end
        end
      end
      csmabo_pkg::PH_TX: begin
        tx_left_next = tx_dec;
        if (tx_dec == '0 && tick.tx_stations == csmabo_pkg::NTX_W'(1)) begin
          deliv              = 1'b1;
          retry_cnt_next     = '0;
          frame_pending_next = 1'b0;
          paused_slots_next  = '0;
          phase_next         = csmabo_pkg::PH_ACK;
          ack_left_next      = 9'(cfg.ack_wait_ticks) + 9'd1;
        end else if (tx_dec == TIMER_BITS'(1) &&
                     tick.tx_stations > csmabo_pkg::NTX_W'(1)) begin
          coll = 1'b1;
          if (retry_cnt != csmabo_pkg::RETRY_MAX) retry_cnt_next = retry_cnt + RW'(1);
          frame_pending_next = 1'b1;
          paused_slots_next  = '0;
          phase_next         = csmabo_pkg::PH_TIMEOUT;
          timeout_left_next  = cfg.ack_wait_ticks;
        end
      end
      csmabo_pkg::PH_TIMEOUT: begin
        timeout_left_next = timeout_dec;
        if (timeout_dec == 8'd0) phase_next = csmabo_pkg::PH_IDLE;
      end
      csmabo_pkg::PH_ACK: begin
        ack_left_next = ack_dec;
        if (ack_dec == 9'd0) begin
          ackc               = 1'b1;
          retry_cnt_next     = '0;
          frame_pending_next = 1'b0;
          paused_slots_next  = '0;
          phase_next         = csmabo_pkg::PH_IDLE;
        end
      end
      default: phase_next = csmabo_pkg::PH_IDLE;
    endcase
  end

  always_comb begin
    res.phase           = csmabo_pkg::phase_code(phase_next);
    res.is_sending      = (phase_next == csmabo_pkg::PH_TX);
    res.is_awaiting_ack = (phase_next == csmabo_pkg::PH_ACK);
    res.backoff_drawn   = drawn;
    res.frame_dropped   = dropped;
    res.collision_seen  = coll;
    res.frame_delivered = deliv;
    res.ack_complete    = ackc;
    res.slots_left      = backoff_left_next;
    res.retry_value     = retry_cnt_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= csmabo_pkg::PH_IDLE;
      difs_left     <= '0;
      backoff_left  <= '0;
      paused_slots  <= '0;
      tx_left       <= '0;
      timeout_left  <= '0;
      ack_left      <= '0;
      retry_cnt     <= '0;
      frame_pending <= 1'b1;
    end else if (advance) begin
      phase         <= phase_next;
      difs_left     <= difs_left_next;
      backoff_left  <= backoff_left_next;
      paused_slots  <= paused_slots_next;
      tx_left       <= tx_left_next;
      timeout_left  <= timeout_left_next;
      ack_left      <= ack_left_next;
      retry_cnt     <= retry_cnt_next;
      frame_pending <= frame_pending_next;
    end
  end

endmodule

// File: rtl/csma_ca_station_backoff_fsm_top.sv
// Top level of the CSMA/CA station access controller with binary exponential backoff.
//
//   port       | dir  | content
//   -----------+------+--------------------------------------------------------
//   tick_in    | sink | one slot tick: busy flag, transmitter count, random, new frame
//   result_out | src  | one status word per tick: phase, event flags, slots, retries
//   cfg        | sink | register writes: index 0..4, always ready
//
// One tick per clock while the result channel accepts results. A tick is held in the input
// register; the state update and its result are computed from it and land in the result
// register. Both stages advance together when the result register is free or being taken;
// while a result waits, one more tick is still taken into an empty input register.
// Reset (synchronous) puts the station in idle with a frame pending and all timers zero.
module csma_ca_station_backoff_fsm_top #(
  parameter int TIMER_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  csmabo_tick_if.sink        tick_in,
  csmabo_result_if.source    result_out,
  csmabo_cfg_if.sink         cfg
);

  csmabo_pkg::cfg_t    cfg_regs;
  csmabo_pkg::tick_t   s1_tick;
  logic                s1_valid;
  csmabo_pkg::result_t s2_res;
  logic                s2_valid;
  csmabo_pkg::result_t core_res;
  logic                s2_load;
  logic                advance;

  assign s2_load       = !s2_valid || result_out.ready;
  assign advance       = s1_valid && s2_load;
  assign tick_in.ready = !s1_valid || s2_load;

  csmabo_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (cfg_regs)
  );

  csmabo_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .tick    (s1_tick),
    .cfg     (cfg_regs),
    .res     (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick_in.ready) begin
      s1_valid <= tick_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_in.valid && tick_in.ready) begin
      s1_tick.medium_busy <= tick_in.medium_busy;
      s1_tick.tx_stations <= tick_in.tx_stations;
      s1_tick.random_word <= tick_in.random_word;
      s1_tick.new_frame   <= tick_in.new_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_load) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_res <= core_res;
    end
  end

  assign result_out.valid           = s2_valid;
  assign result_out.phase           = s2_res.phase;
  assign result_out.is_sending      = s2_res.is_sending;
  assign result_out.is_awaiting_ack = s2_res.is_awaiting_ack;
  assign result_out.backoff_drawn   = s2_res.backoff_drawn;
  assign result_out.frame_dropped   = s2_res.frame_dropped;
  assign result_out.collision_seen  = s2_res.collision_seen;
  assign result_out.frame_delivered = s2_res.frame_delivered;
  assign result_out.ack_complete    = s2_res.ack_complete;
  assign result_out.slots_left      = s2_res.slots_left;
  assign result_out.retry_value     = s2_res.retry_value;

  // a buffered tick always reaches the result register when that is empty
  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s2_valid |=> s2_valid)
    else $error("buffered tick did not advance to result register");

  // a tick carries at most one event
  a_one_event: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> $onehot0({s2_res.backoff_drawn, s2_res.frame_dropped,
                           s2_res.collision_seen, s2_res.frame_delivered,
                           s2_res.ack_complete}))
    else $error("more than one event flagged in one tick");

  a_collision_timeout: assert property (@(posedge clk) disable iff (rst)
    s2_valid && s2_res.collision_seen |->
      s2_res.phase == csmabo_pkg::PHASE_CODE_TIMEOUT && s2_res.retry_value != '0)
    else $error("collision without timeout or retry increment");

  a_delivery_ack: assert property (@(posedge clk) disable iff (rst)
    s2_valid && s2_res.frame_delivered |->
      s2_res.is_awaiting_ack && s2_res.retry_value == '0)
    else $error("delivery did not enter ACK wait with cleared retries");

endmodule
